// ===== rtl/clpg_pkg.sv =====
package clpg_pkg;

  localparam int CoordBits = 10;
  localparam int DeltaBits = CoordBits + 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef struct packed {
    logic                 op;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
    logic [7:0]           pen_color;
  } in_word_t;

  typedef struct packed {
    logic [CoordBits:0] pixel_x;
    logic [CoordBits:0] pixel_y;
    logic [7:0]         pixel_color;
    logic               write_pixel;
    logic               line_done;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch endpoints, request the first divide if dx is nonzero
    logic emit;      // build result word and advance row/column
    logic div_start; // start a divide for the current column
  } clpg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic need_div;  // after load or emit, a new column row is needed
  } clpg_sts_t;

endpackage

// ===== rtl/clpg_div.sv =====
module clpg_div import clpg_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [2*DeltaBits:0] num,
  input  logic signed [DeltaBits-1:0] den,
  output logic                        done,
  output logic signed [DeltaBits-1:0] quo
);
  localparam int NBits = 2*DeltaBits + 1;
  localparam int CntBits = $clog2(NBits + 1);

  logic [NBits-1:0]     q_r, q_nxt;
  logic [DeltaBits-1:0] rem_r, rem_nxt;
  logic [DeltaBits-1:0] d_r, d_nxt;
  logic                 neg_r, neg_nxt;
  logic [CntBits-1:0]   cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DeltaBits+1:0] trial;
  logic [DeltaBits:0]   shifted;
  logic [NBits-1:0]     qneg;

  // restoring divide on magnitudes, one quotient bit per cycle
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; run_nxt = run_r; done_nxt = 1'b0;
    shifted = {rem_r, q_r[NBits-1]};
    trial = {1'b0, shifted} - {2'b00, d_r};
    if (start) begin
      q_nxt = num[NBits-1] ? NBits'(-num) : NBits'(num);
      d_nxt = den[DeltaBits-1] ? DeltaBits'(-den) : DeltaBits'(den);
      neg_nxt = num[NBits-1] ^ den[DeltaBits-1];
      rem_nxt = '0;
      cnt_nxt = CntBits'(NBits);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[DeltaBits+1]) rem_nxt = trial[DeltaBits-1:0];
      else                     rem_nxt = shifted[DeltaBits-1:0];
      q_nxt = {q_r[NBits-2:0], ~trial[DeltaBits+1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntBits'(1)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign qneg = neg_r ? -q_r : q_r;
  assign quo  = qneg[DeltaBits-1:0];
  assign done = done_r;
endmodule

// ===== rtl/clpg_datapath.sv =====
module clpg_datapath import clpg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clpg_cmd_t            cmd,
  output clpg_sts_t            sts,
  input  in_word_t             in_word,
  input  logic [CoordBits-1:0] org_x,
  input  logic [CoordBits-1:0] org_y,
  input  logic [CoordBits-1:0] win_w,
  input  logic [CoordBits-1:0] win_h,
  output out_word_t            res
);
  typedef logic signed [DeltaBits-1:0] sd_t;

  logic [CoordBits-1:0] ax_r, ay_r;
  sd_t dx_r, dy_r, col_r, cur_r, tgt_r;
  logic [7:0] col_color_r;
  logic busy_r, need_r;
  sd_t dx_in, dy_in, sgn_x, col_next, quo;
  logic signed [2*DeltaBits:0] num;
  logic div_done;
  logic signed [DeltaBits+1:0] relx, rely;
  logic in_win;

  assign dx_in = sd_t'({1'b0, in_word.end_x}) - sd_t'({1'b0, in_word.start_x});
  assign dy_in = sd_t'({1'b0, in_word.end_y}) - sd_t'({1'b0, in_word.start_y});
  assign sgn_x = dx_r[DeltaBits-1] ? -sd_t'(1) : sd_t'(1);
  assign col_next = col_r + sgn_x;
  assign num = (2*DeltaBits+1)'(dy_r) * (2*DeltaBits+1)'(col_r);

  clpg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num), .den(dx_r), .done(div_done), .quo(quo)
  );

  assign relx = (DeltaBits+2)'($signed({1'b0, ax_r})) + (DeltaBits+2)'(col_r);
  assign rely = (DeltaBits+2)'($signed({1'b0, ay_r})) + (DeltaBits+2)'(cur_r);
  assign in_win = !relx[DeltaBits+1] && !rely[DeltaBits+1]
               && relx <= (DeltaBits+2)'($signed({1'b0, win_w}))
               && rely <= (DeltaBits+2)'($signed({1'b0, win_h}));

  // result word for the current pixel
  always_comb begin
    res = '0;
    if (cmd.load) begin
      res = '0;
    end else if (!busy_r) begin
      res.line_done = 1'b1;
    end else begin
      res.pixel_color = col_color_r;
      if (in_win) begin
        res.write_pixel = 1'b1;
        res.pixel_x = relx[CoordBits:0] + {1'b0, org_x};
        res.pixel_y = rely[CoordBits:0] + {1'b0, org_y};
      end
      res.line_done = (cur_r == tgt_r) && !(dx_r != '0 && col_r != dx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; need_r <= 1'b0;
      ax_r <= '0; ay_r <= '0; dx_r <= '0; dy_r <= '0;
      col_r <= '0; cur_r <= '0; tgt_r <= '0; col_color_r <= '0;
    end else begin
      if (div_done) begin
        tgt_r <= quo;
        need_r <= 1'b0;
      end
      if (cmd.load) begin
        ax_r <= in_word.start_x; ay_r <= in_word.start_y;
        dx_r <= dx_in; dy_r <= dy_in;
        col_color_r <= in_word.pen_color;
        cur_r <= '0;
        busy_r <= 1'b1;
        if (dx_in == '0) begin
          col_r <= '0;
          need_r <= 1'b0;
          tgt_r <= (dy_in == '0) ? '0 :
                   (dy_in[DeltaBits-1] ? dy_in + sd_t'(1) : dy_in - sd_t'(1));
        end else begin
          col_r <= dx_in[DeltaBits-1] ? -sd_t'(1) : sd_t'(1);
          need_r <= 1'b1;
        end
      end else if (cmd.emit && busy_r) begin
        if (cur_r != tgt_r) begin
          cur_r <= (tgt_r > cur_r) ? cur_r + sd_t'(1) : cur_r - sd_t'(1);
        end else if (dx_r != '0 && col_r != dx_r) begin
          col_r <= col_next;
          need_r <= 1'b1;
        end else begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.need_div = need_r;
endmodule

// ===== rtl/clpg_ctrl.sv =====
module clpg_ctrl import clpg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_op,
  output logic      out_valid,
  input  logic      out_stall,
  input  clpg_sts_t sts,
  output clpg_cmd_t cmd,
  output logic      out_load
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       acc;

  // take a word only when not dividing and the output slot is free
  assign in_stall = (state_r != S_IDLE) || sts.need_div || (ovalid_r && out_stall);
  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd.load = acc && (in_op == OP_LOAD);
    cmd.emit = acc && (in_op == OP_STEP);
    if (acc) ovalid_nxt = 1'b1;
    unique case (state_r)
      S_IDLE:  if (sts.need_div && !acc) state_nxt = S_START;
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT:  if (sts.div_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_load  = acc;
endmodule

// ===== rtl/clipped_line_pixel_generator.sv =====
// Clipped line pixel generator.
// Input channel (in_valid/in_stall/in_word): a load word latches the two
// endpoints and the pen color; each step word yields one pixel of the line.
// Output channel (out_valid/out_stall/out_word): exactly one result word
// per input word, in order. A load returns an all-zero word; a step after
// the end of the line returns only line_done set.
// Configuration: APB-style port sets window origin, width and height;
// write it only while the block is idle.
// Latency: a result word is valid the cycle after its input is taken.
// Throughput: steps inside one column are taken every cycle unless the
// output stalls. A load with nonzero dx, and each step that moves to a new
// column, starts the row divide dy*i/dx in a restoring divider of
// 2*(CoordBits+1)+1 = 23 quotient bits; no word is taken until it finishes.
// Reset: no line is loaded, registers return to origin 0, width 319,
// height 199. A stalled result holds, and further input is held off until
// the result is taken.
module clipped_line_pixel_generator import clpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [CoordBits-1:0] org_x_r, org_y_r, win_w_r, win_h_r;
  clpg_cmd_t cmd;
  clpg_sts_t sts;
  out_word_t res;
  out_word_t out_r;
  logic acc;

  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0;
      win_w_r <= CoordBits'(319); win_h_r <= CoordBits'(199);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        REG_ORIGIN_X: org_x_r <= cfg_pwdata[CoordBits-1:0];
        REG_ORIGIN_Y: org_y_r <= cfg_pwdata[CoordBits-1:0];
        REG_WIDTH:    win_w_r <= cfg_pwdata[CoordBits-1:0];
        REG_HEIGHT:   win_h_r <= cfg_pwdata[CoordBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_ORIGIN_X: cfg_prdata = 32'(org_x_r);
      REG_ORIGIN_Y: cfg_prdata = 32'(org_y_r);
      REG_WIDTH:    cfg_prdata = 32'(win_w_r);
      REG_HEIGHT:   cfg_prdata = 32'(win_h_r);
      default:      cfg_prdata = '0;
    endcase
  end

  clpg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_word.op), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd), .out_load(acc)
  );

  clpg_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_word(in_word),
    .org_x(org_x_r), .org_y(org_y_r), .win_w(win_w_r), .win_h(win_h_r),
    .res(res)
  );

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (acc) out_r <= res;
  end
  assign out_word = out_r;
endmodule
